@@ src/edrc_pkg.sv @@
// ----------------------------------------------------------------------------
// Ethernet DMA ring controller package
// Event codes, register selects, control bit masks and the result type.
// ----------------------------------------------------------------------------
package edrc_pkg;

  localparam logic [2:0] KIND_RX_CTRL  = 3'd0;
  localparam logic [2:0] KIND_TX_CTRL  = 3'd1;
  localparam logic [2:0] KIND_RX_TAIL  = 3'd2;
  localparam logic [2:0] KIND_TX_COUNT = 3'd3;
  localparam logic [2:0] KIND_READ     = 3'd4;
  localparam logic [2:0] KIND_RX_DONE  = 3'd5;

  localparam logic [2:0] SEL_TX_CTRL   = 3'd0;
  localparam logic [2:0] SEL_RX_CTRL   = 3'd1;
  localparam logic [2:0] SEL_HEAD      = 3'd2;
  localparam logic [2:0] SEL_TAIL      = 3'd3;
  localparam logic [2:0] SEL_COUNT0_HI = 3'd4;
  localparam logic [2:0] SEL_COUNT0_LO = 3'd5;
  localparam logic [2:0] SEL_COUNT1_HI = 3'd6;
  localparam logic [2:0] SEL_COUNT1_LO = 3'd7;

  localparam logic [7:0] CTL_IF      = 8'h01;
  localparam logic [7:0] CTL_RUN     = 8'h02;
  localparam logic [7:0] CTL_IE      = 8'h08;
  localparam logic [7:0] CTL_OVERRUN = 8'h40;
  localparam logic [7:0] CTL_RESET   = 8'h80;

  localparam logic [7:0] TX_EMPTY0 = 8'h20;
  localparam logic [7:0] TX_EMPTY1 = 8'h40;

  localparam logic [31:0] TX_AREA_OFFSET = 32'h0001_4000;
  localparam logic [31:0] TX_SET_STRIDE  = 32'h0000_0800;

  // Frame length plus header overhead plus rounding to whole pages.
  localparam logic [11:0] FRAME_PAGE_ROUND = 12'd263;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rx_accepted;
    logic [31:0] rx_start_addr;
    logic        tx_valid;
    logic [31:0] tx_addr_low;
    logic [31:0] tx_addr_high;
    logic        tx_two_bytes;
    logic        tx_last;
    logic        rx_irq;
    logic        tx_irq;
  } result_t;

endpackage

@@ src/edrc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the DMA base address with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface edrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/edrc_in_if.sv @@
// ----------------------------------------------------------------------------
// Event input channel
// One transaction is one register access, frame completion or transmit request.
// ----------------------------------------------------------------------------
interface edrc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        tx_request;
  logic [7:0]  write_data;
  logic [2:0]  reg_select;
  logic [10:0] frame_length;
  logic        mac_accepts;

  modport source (
    output valid, output kind, output tx_request, output write_data,
    output reg_select, output frame_length, output mac_accepts, input ready
  );
  modport sink (
    input valid, input kind, input tx_request, input write_data,
    input reg_select, input frame_length, input mac_accepts, output ready
  );
endinterface

@@ src/edrc_out_if.sv @@
// ----------------------------------------------------------------------------
// Result output channel
// One transaction per accepted event, with read data, addresses and interrupts.
// ----------------------------------------------------------------------------
interface edrc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        rx_accepted;
  logic [31:0] rx_start_addr;
  logic        tx_valid;
  logic [31:0] tx_addr_low;
  logic [31:0] tx_addr_high;
  logic        tx_two_bytes;
  logic        tx_last;
  logic        rx_irq;
  logic        tx_irq;

  modport source (
    output valid, output read_data, output rx_accepted, output rx_start_addr,
    output tx_valid, output tx_addr_low, output tx_addr_high, output tx_two_bytes,
    output tx_last, output rx_irq, output tx_irq, input ready
  );
  modport sink (
    input valid, input read_data, input rx_accepted, input rx_start_addr,
    input tx_valid, input tx_addr_low, input tx_addr_high, input tx_two_bytes,
    input tx_last, input rx_irq, input tx_irq, output ready
  );
endinterface

@@ src/edrc_out_buf.sv @@
// ----------------------------------------------------------------------------
// Result buffer
// Output register with a skid entry, so a new result is taken while one waits.
// ----------------------------------------------------------------------------
module edrc_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  edrc_pkg::result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output edrc_pkg::result_t out_data
);
  import edrc_pkg::*;

  logic    head_vld_r, head_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t head_r, head_nxt;
  result_t skid_r, skid_nxt;
  logic    head_free;

  assign head_free = !head_vld_r || out_ready;
  assign can_push  = !skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_data  = head_r;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (head_free) begin
      if (skid_vld_r) begin
        head_vld_nxt = 1'b1;
        head_nxt     = skid_r;
        skid_vld_nxt = push;
        skid_nxt     = push_data;
      end else begin
        head_vld_nxt = push;
        head_nxt     = push_data;
      end
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

@@ src/ethernet_dma_ring_controller.sv @@
// ----------------------------------------------------------------------------
// Ethernet DMA ring controller
// Receive page ring and dual transmit buffer control for an Ethernet DMA.
// ----------------------------------------------------------------------------
// Usage: each transaction on in_ch is one event: a control, tail or count
// write, a register read, a frame completion or a transmit word request.
// Every event yields exactly one transaction on out_ch, in order.
// cfg_ch writes the DMA base address and is always ready; it must be written
// only while the block is idle, which the block itself does not enforce.
// An accepted event's result goes into the result buffer, whose head register drives out_ch.
// One event is taken per cycle while in_ch.ready is high, set by the single
// pass of the event logic between the state registers and the result register.
// A two-entry result buffer lets one more event in while a result waits;
// in_ch.ready falls only when both entries are occupied after a receiver
// stall, and rises again once out_ch has taken a result.
// Synchronous reset clears the control registers, ring pointers, counts,
// positions and base address, and empties the result buffer.
// ----------------------------------------------------------------------------
module ethernet_dma_ring_controller #(
  parameter int RING_PAGE_COUNT = 192,
  parameter int TX_BUFFER_BYTES = 2048
) (
  input  logic       clk,
  input  logic       rst_n,
  edrc_cfg_if.sink   cfg_ch,
  edrc_in_if.sink    in_ch,
  edrc_out_if.source out_ch
);
  import edrc_pkg::*;

  localparam int POS_W = $clog2(TX_BUFFER_BYTES);
  localparam logic [8:0] RING_N = 9'(RING_PAGE_COUNT);
  localparam logic [POS_W:0] TX_BUF = (POS_W + 1)'(TX_BUFFER_BYTES);

  logic [31:0] dma_base_r;
  logic [31:0] tx_base0_r;
  logic [31:0] tx_base1_r;

  logic [7:0]       rx_ctrl_r, rx_ctrl_nxt;
  logic [7:0]       tx_ctrl_r, tx_ctrl_nxt;
  logic [7:0]       ring_head_r, ring_head_nxt;
  logic [7:0]       ring_tail_r, ring_tail_nxt;
  logic             ring_full_r, ring_full_nxt;
  logic [15:0]      tx_bytes_r [2];
  logic [15:0]      tx_bytes_nxt [2];
  logic [POS_W-1:0] tx_pos_r [2];
  logic [POS_W-1:0] tx_pos_nxt [2];
  logic             tx_set_r, tx_set_nxt;

  logic    in_fire;
  logic    buf_can_push;
  result_t res;
  result_t out_data;

  logic [11:0]      len_sum;
  logic [3:0]       pages;
  logic [8:0]       avail_raw;
  logic [8:0]       avail;
  logic [8:0]       head_adv;
  logic [7:0]       head_new;
  logic             fits;
  logic             svc_set;
  logic [15:0]      svc_cnt;
  logic [POS_W-1:0] svc_pos;
  logic             svc_two;
  logic [POS_W:0]   pos_p1;
  logic [POS_W:0]   pos_p2;
  logic [POS_W-1:0] pos_p1_w;
  logic [POS_W-1:0] pos_p2_w;
  logic [31:0]      svc_base;
  logic [15:0]      svc_step;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = buf_can_push;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    len_sum   = 12'(in_ch.frame_length) + FRAME_PAGE_ROUND;
    pages     = len_sum[11:8];
    avail_raw = 9'(ring_tail_r) + RING_N - 9'(ring_head_r) - 9'd1;
    if (avail_raw >= RING_N) begin
      avail_raw = avail_raw - RING_N;
    end
    avail    = ring_full_r ? 9'd0 : avail_raw + 9'd1;
    fits     = 9'(pages) <= avail;
    head_adv = 9'(ring_head_r) + 9'(pages);
    if (head_adv >= RING_N) begin
      head_adv = head_adv - RING_N;
    end
    head_new = head_adv[7:0];

    svc_set  = tx_set_r ^ (tx_bytes_r[tx_set_r] == 16'd0);
    svc_cnt  = tx_bytes_r[svc_set];
    svc_pos  = tx_pos_r[svc_set];
    svc_two  = |svc_cnt[15:1];
    svc_step = svc_two ? 16'd2 : 16'd1;
    pos_p1   = (POS_W + 1)'(svc_pos) + (POS_W + 1)'(1);
    if (pos_p1 >= TX_BUF) begin
      pos_p1 = pos_p1 - TX_BUF;
    end
    pos_p2 = (POS_W + 1)'(svc_pos) + (POS_W + 1)'(2);
    if (pos_p2 >= TX_BUF) begin
      pos_p2 = pos_p2 - TX_BUF;
    end
    pos_p1_w = pos_p1[POS_W-1:0];
    pos_p2_w = pos_p2[POS_W-1:0];
    svc_base = svc_set ? tx_base1_r : tx_base0_r;

    rx_ctrl_nxt     = rx_ctrl_r;
    tx_ctrl_nxt     = tx_ctrl_r;
    ring_head_nxt   = ring_head_r;
    ring_tail_nxt   = ring_tail_r;
    ring_full_nxt   = ring_full_r;
    tx_bytes_nxt[0] = tx_bytes_r[0];
    tx_bytes_nxt[1] = tx_bytes_r[1];
    tx_pos_nxt[0]   = tx_pos_r[0];
    tx_pos_nxt[1]   = tx_pos_r[1];
    tx_set_nxt      = tx_set_r;
    res             = '0;

    if (in_fire) begin
      if (in_ch.tx_request) begin
        if ((tx_ctrl_r & CTL_RUN) != 8'h00) begin
          tx_set_nxt = svc_set;
          if (svc_cnt != 16'd0) begin
            res.tx_valid     = 1'b1;
            res.tx_addr_low  = svc_base + 32'(svc_pos);
            res.tx_addr_high = svc_two ? svc_base + 32'(pos_p1_w) : 32'd0;
            res.tx_two_bytes = svc_two;
            res.tx_last      = svc_cnt == svc_step;
            if (in_ch.mac_accepts) begin
              tx_pos_nxt[svc_set]   = svc_two ? pos_p2_w : pos_p1_w;
              tx_bytes_nxt[svc_set] = svc_cnt - svc_step;
              if (svc_cnt == svc_step) begin
                tx_ctrl_nxt = tx_ctrl_r | CTL_IF;
                tx_set_nxt  = !svc_set;
              end
            end
          end
        end
      end else begin
        case (in_ch.kind)
          KIND_RX_CTRL: begin
            if ((in_ch.write_data & CTL_RESET) != 8'h00) begin
              rx_ctrl_nxt   = 8'h00;
              ring_head_nxt = 8'd0;
              ring_tail_nxt = 8'd0;
              ring_full_nxt = 1'b0;
            end else begin
              rx_ctrl_nxt = (rx_ctrl_r & (CTL_IF | CTL_OVERRUN) & ~in_ch.write_data)
                          | (in_ch.write_data & (CTL_RUN | CTL_IE));
            end
          end
          KIND_TX_CTRL: begin
            if ((in_ch.write_data & CTL_RESET) != 8'h00) begin
              tx_ctrl_nxt     = 8'h00;
              tx_set_nxt      = 1'b0;
              tx_bytes_nxt[0] = 16'd0;
              tx_bytes_nxt[1] = 16'd0;
              tx_pos_nxt[0]   = '0;
              tx_pos_nxt[1]   = '0;
            end else begin
              tx_ctrl_nxt = (tx_ctrl_r & CTL_IF & ~in_ch.write_data)
                          | (in_ch.write_data & (CTL_RUN | CTL_IE));
            end
          end
          KIND_RX_TAIL: begin
            if (9'(in_ch.write_data) < RING_N) begin
              if (in_ch.write_data != ring_tail_r) begin
                ring_full_nxt = 1'b0;
              end
              ring_tail_nxt = in_ch.write_data;
            end
          end
          KIND_TX_COUNT: begin
            if (in_ch.reg_select[2]) begin
              if (in_ch.reg_select[0]) begin
                tx_bytes_nxt[in_ch.reg_select[1]] =
                  {tx_bytes_r[in_ch.reg_select[1]][15:8], in_ch.write_data};
              end else begin
                tx_bytes_nxt[in_ch.reg_select[1]] =
                  {in_ch.write_data, tx_bytes_r[in_ch.reg_select[1]][7:0]};
              end
              tx_pos_nxt[in_ch.reg_select[1]] = '0;
            end
          end
          KIND_READ: begin
            case (in_ch.reg_select)
              SEL_TX_CTRL: begin
                res.read_data = tx_ctrl_r
                              | ((tx_bytes_r[0] == 16'd0) ? TX_EMPTY0 : 8'h00)
                              | ((tx_bytes_r[1] == 16'd0) ? TX_EMPTY1 : 8'h00);
              end
              SEL_RX_CTRL:   res.read_data = rx_ctrl_r;
              SEL_HEAD:      res.read_data = ring_head_r;
              SEL_TAIL:      res.read_data = ring_tail_r;
              SEL_COUNT0_HI: res.read_data = tx_bytes_r[0][15:8];
              SEL_COUNT0_LO: res.read_data = tx_bytes_r[0][7:0];
              SEL_COUNT1_HI: res.read_data = tx_bytes_r[1][15:8];
              SEL_COUNT1_LO: res.read_data = tx_bytes_r[1][7:0];
              default:       res.read_data = 8'h00;
            endcase
          end
          KIND_RX_DONE: begin
            if ((rx_ctrl_r & CTL_RUN) != 8'h00 && (rx_ctrl_r & CTL_OVERRUN) == 8'h00) begin
              if (fits) begin
                res.rx_accepted   = 1'b1;
                res.rx_start_addr = dma_base_r + {16'd0, ring_head_r, 8'd0};
                ring_head_nxt     = head_new;
                ring_full_nxt     = head_new == ring_tail_r;
              end
              if (!fits || head_new == ring_tail_r) begin
                rx_ctrl_nxt = (rx_ctrl_r & ~CTL_RUN) | CTL_OVERRUN | CTL_IF;
              end else begin
                rx_ctrl_nxt = rx_ctrl_r | CTL_IF;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    res.rx_irq = (rx_ctrl_nxt & (CTL_IE | CTL_IF)) == (CTL_IE | CTL_IF);
    res.tx_irq = (tx_ctrl_nxt & (CTL_IE | CTL_IF)) == (CTL_IE | CTL_IF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dma_base_r  <= 32'd0;
      tx_base0_r  <= TX_AREA_OFFSET;
      tx_base1_r  <= TX_AREA_OFFSET + TX_SET_STRIDE;
    end else if (cfg_ch.valid) begin
      dma_base_r  <= cfg_ch.data;
      tx_base0_r  <= cfg_ch.data + TX_AREA_OFFSET;
      tx_base1_r  <= cfg_ch.data + TX_AREA_OFFSET + TX_SET_STRIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_ctrl_r     <= 8'h00;
      tx_ctrl_r     <= 8'h00;
      ring_head_r   <= 8'd0;
      ring_tail_r   <= 8'd0;
      ring_full_r   <= 1'b0;
      tx_bytes_r[0] <= 16'd0;
      tx_bytes_r[1] <= 16'd0;
      tx_pos_r[0]   <= '0;
      tx_pos_r[1]   <= '0;
      tx_set_r      <= 1'b0;
    end else begin
      rx_ctrl_r     <= rx_ctrl_nxt;
      tx_ctrl_r     <= tx_ctrl_nxt;
      ring_head_r   <= ring_head_nxt;
      ring_tail_r   <= ring_tail_nxt;
      ring_full_r   <= ring_full_nxt;
      tx_bytes_r[0] <= tx_bytes_nxt[0];
      tx_bytes_r[1] <= tx_bytes_nxt[1];
      tx_pos_r[0]   <= tx_pos_nxt[0];
      tx_pos_r[1]   <= tx_pos_nxt[1];
      tx_set_r      <= tx_set_nxt;
    end
  end

  edrc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (res),
    .can_push  (buf_can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.read_data     = out_data.read_data;
  assign out_ch.rx_accepted   = out_data.rx_accepted;
  assign out_ch.rx_start_addr = out_data.rx_start_addr;
  assign out_ch.tx_valid      = out_data.tx_valid;
  assign out_ch.tx_addr_low   = out_data.tx_addr_low;
  assign out_ch.tx_addr_high  = out_data.tx_addr_high;
  assign out_ch.tx_two_bytes  = out_data.tx_two_bytes;
  assign out_ch.tx_last       = out_data.tx_last;
  assign out_ch.rx_irq        = out_data.rx_irq;
  assign out_ch.tx_irq        = out_data.tx_irq;

`ifndef NO_ASSERTIONS
  a_ring_ptrs_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (9'(ring_head_r) < RING_N) && (9'(ring_tail_r) < RING_N))
    else $error("ring pointer beyond the page count");

  a_full_means_equal: assert property (@(posedge clk) disable iff (!rst_n)
    ring_full_r |-> (ring_head_r == ring_tail_r))
    else $error("ring marked full with head and tail apart");

  a_tx_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((POS_W + 1)'(tx_pos_r[0]) < TX_BUF) && ((POS_W + 1)'(tx_pos_r[1]) < TX_BUF))
    else $error("transmit position beyond the buffer size");

  a_tx_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.tx_request && (tx_ctrl_r & CTL_RUN) == 8'h00)
    |=> ($stable(tx_bytes_r[0]) && $stable(tx_bytes_r[1]) && $stable(tx_set_r)))
    else $error("transmit state changed while transmit is stopped");
`endif

endmodule
